// File: sv/phe_pkg.sv
// shared constants, types and helpers of the piecewise hazard evaluator
package phe_pkg;

    localparam int NUM_INTERVALS        = 16;
    localparam int NUM_TD_COVARIATES    = 4;
    localparam int NUM_FIXED_COVARIATES = 4;

    localparam int TD_DEPTH = NUM_TD_COVARIATES * NUM_INTERVALS;
    localparam int FX_DEPTH = (NUM_FIXED_COVARIATES > 0) ? NUM_FIXED_COVARIATES : 1;
    localparam int IW       = (NUM_INTERVALS > 1) ? $clog2(NUM_INTERVALS) : 1;
    localparam int TD_AW    = (TD_DEPTH > 1) ? $clog2(TD_DEPTH) : 1;
    localparam int TC_AW    = (NUM_TD_COVARIATES > 1) ? $clog2(NUM_TD_COVARIATES) : 1;
    localparam int FX_AW    = (FX_DEPTH > 1) ? $clog2(FX_DEPTH) : 1;
    localparam int CNT_W    = (TC_AW > FX_AW) ? TC_AW : FX_AW;

    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    // exponential: x = k*ln2 + r, ln2 in q16.16
    localparam int          LN2_Q16    = 45426;
    localparam int          EXP_BIAS_K = 47276;
    localparam logic [32:0] EXP_BIAS   = 33'(64'(LN2_Q16) * 64'(EXP_BIAS_K));
    localparam logic [63:0] K_RECIP_W  = (64'd1 << 48) / 64'd45426;
    localparam logic [32:0] K_RECIP    = K_RECIP_W[32:0];
    localparam int          EXP_TERMS  = 12;

    typedef enum logic [2:0] {
        OP_TD_COEF = 3'd0,
        OP_WIDTH   = 3'd1,
        OP_FX_COEF = 3'd2,
        OP_TD_COV  = 3'd3,
        OP_FX_COV  = 3'd4,
        OP_EVAL    = 3'd5
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [5:0]         index;
        logic signed [31:0] data;
        logic [IW-1:0]      t0;
        logic [31:0]        x0;
        logic [IW-1:0]      t1;
        logic [31:0]        x1;
        logic               last;
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FX_MUL, ST_FX_ACC, ST_FX_END, ST_TD_RD, ST_TD_MUL, ST_TD_ACC,
        ST_EXP_GO, ST_EXP_WAIT, ST_TIME_MUL, ST_TIME_ACC, ST_WID_MUL, ST_WID_ACC,
        ST_FIN, ST_SC0_MUL, ST_SC0, ST_SC1_MUL, ST_SC1, ST_OUT
    } back_state_t;

    typedef enum logic [1:0] {PH_LP0, PH_LP1, PH_K, PH_FE} phase_t;

    typedef enum logic [2:0] {EX_IDLE, EX_KFIX, EX_T1, EX_T2, EX_T3, EX_SH} exp_state_t;

    // floor(2^32 / n) for the taylor term divisions
    function automatic logic [32:0] term_recip(input logic [3:0] n);
        logic [32:0] v;
        case (n)
            4'd1:    v = 33'd4294967296;
            4'd2:    v = 33'd2147483648;
            4'd3:    v = 33'd1431655765;
            4'd4:    v = 33'd1073741824;
            4'd5:    v = 33'd858993459;
            4'd6:    v = 33'd715827882;
            4'd7:    v = 33'd613566756;
            4'd8:    v = 33'd536870912;
            4'd9:    v = 33'd477218588;
            4'd10:   v = 33'd429496729;
            4'd11:   v = 33'd390451572;
            4'd12:   v = 33'd357913941;
            default: v = 33'd0;
        endcase
        return v;
    endfunction

    function automatic logic [IW-1:0] clamp_interval(input logic [3:0] t);
        logic [6:0] t7;
        logic [6:0] c7;
        t7 = 7'(t);
        c7 = (t7 >= 7'(NUM_INTERVALS)) ? 7'(NUM_INTERVALS - 1) : t7;
        return IW'(c7);
    endfunction

    function automatic logic out_of_s32(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic out_of_u32(input logic signed [63:0] v);
        return (v < 64'sd0) || (v > 64'sh00000000FFFFFFFF);
    endfunction

    function automatic logic [31:0] clamp_u32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v < 64'sd0) begin
            r = 32'd0;
        end else if (v > 64'sh00000000FFFFFFFF) begin
            r = 32'hFFFFFFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/phe_front.sv
// front end: decodes incoming beats, drops ignored ones, clamps intervals
module phe_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [111:0]        s_tdata,  // index, data_value, entry_interval,
                                          // entry_time_in_interval, exit_interval,
                                          // exit_time_in_interval, zero pad
    input  logic [2:0]          s_tuser,  // opcode
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                q_push,
    output phe_pkg::cmd_t       q_din
);

    phe_pkg::op_t op;
    logic         keep;
    logic [31:0]  idx32;

    always_comb begin
        op    = phe_pkg::op_t'(s_tuser);
        idx32 = 32'(s_tdata[5:0]);
        case (op)
            phe_pkg::OP_TD_COEF: keep = idx32 < 32'(phe_pkg::TD_DEPTH);
            phe_pkg::OP_WIDTH:   keep = idx32 < 32'(phe_pkg::NUM_INTERVALS);
            phe_pkg::OP_FX_COEF: keep = idx32 < 32'(phe_pkg::NUM_FIXED_COVARIATES);
            phe_pkg::OP_TD_COV:  keep = idx32 < 32'(phe_pkg::NUM_TD_COVARIATES);
            phe_pkg::OP_FX_COV:  keep = idx32 < 32'(phe_pkg::NUM_FIXED_COVARIATES);
            phe_pkg::OP_EVAL:    keep = 1'b1;
            default:             keep = 1'b0;
        endcase

        q_din.op    = op;
        q_din.index = s_tdata[5:0];
        q_din.data  = s_tdata[37:6];
        q_din.t0    = phe_pkg::clamp_interval(s_tdata[41:38]);
        q_din.x0    = s_tdata[73:42];
        q_din.t1    = phe_pkg::clamp_interval(s_tdata[77:74]);
        q_din.x1    = s_tdata[109:78];
        q_din.last  = s_tlast;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule

// File: sv/phe_fifo.sv
// short command queue between front end and back end
module phe_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  phe_pkg::cmd_t din,
    input  logic          pop,
    output phe_pkg::cmd_t dout,
    output logic          empty,
    output logic          full
);

    phe_pkg::cmd_t                  entries_reg [phe_pkg::QUEUE_DEPTH];
    logic [phe_pkg::QAW-1:0]        wptr_reg, wptr_next;
    logic [phe_pkg::QAW-1:0]        rptr_reg, rptr_next;
    logic [phe_pkg::QCW-1:0]        count_reg, count_next;
    logic                           do_push, do_pop;

    assign empty   = count_reg == phe_pkg::QCW'(0);
    assign full    = count_reg == phe_pkg::QCW'(phe_pkg::QUEUE_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entries_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == phe_pkg::QAW'(phe_pkg::QUEUE_DEPTH - 1)) ?
                        phe_pkg::QAW'(0) : wptr_reg + phe_pkg::QAW'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == phe_pkg::QAW'(phe_pkg::QUEUE_DEPTH - 1)) ?
                        phe_pkg::QAW'(0) : rptr_reg + phe_pkg::QAW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + phe_pkg::QCW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - phe_pkg::QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wptr_reg] <= din;
        end
    end

endmodule

// File: sv/phe_exp.sv
// iterative q16.16 exponential: range reduction by ln2, 12-term taylor series
module phe_exp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] x,
    output logic               done,
    output logic [31:0]        result,
    output logic               ovf
);

    phe_pkg::exp_state_t state_reg, state_next;

    logic [32:0]        xoff;
    logic [32:0]        xoff_reg;
    logic [65:0]        kq_reg;
    logic signed [17:0] k_reg;
    logic [29:0]        r30_reg;
    logic [30:0]        term_reg;
    logic [31:0]        sum_reg;
    logic [3:0]         n_reg;
    logic [60:0]        p_reg;
    logic [30:0]        a_reg;
    logic [63:0]        dq_reg;
    logic               done_reg;
    logic [31:0]        result_reg;
    logic               ovf_reg;

    logic [16:0]        kq0;
    logic [33:0]        rr;
    logic [16:0]        kq;
    logic [15:0]        rem16;
    logic [31:0]        tq0;
    logic [35:0]        trem;
    logic [31:0]        tq;
    logic signed [17:0] sl, sr;
    logic [63:0]        shv;
    logic [31:0]        sh_res;
    logic               sh_ovf;
    logic signed [34:0] xs;

    always_comb begin
        xs   = 35'(x) + 35'(phe_pkg::EXP_BIAS);
        xoff = xs[32:0];

        kq0 = kq_reg[64:48];
        rr  = 34'(xoff_reg) - 34'(kq0) * 34'(phe_pkg::LN2_Q16);
        if (rr >= 34'(phe_pkg::LN2_Q16)) begin
            kq    = kq0 + 17'd1;
            rem16 = 16'(rr - 34'(phe_pkg::LN2_Q16));
        end else begin
            kq    = kq0;
            rem16 = rr[15:0];
        end

        tq0  = dq_reg[63:32];
        trem = 36'(a_reg) - 36'(tq0) * 36'(n_reg);
        tq   = (trem >= 36'(n_reg)) ? tq0 + 32'd1 : tq0;

        // scale e^r by 2^(k-14) into q16.16
        sl     = k_reg - 18'sd14;
        sr     = 18'sd14 - k_reg;
        shv    = '0;
        sh_res = '0;
        sh_ovf = 1'b0;
        if (k_reg >= 18'sd14) begin
            if (sl > 18'sd32) begin
                sh_ovf = 1'b1;
                sh_res = 32'hFFFFFFFF;
            end else begin
                shv = 64'(sum_reg) << sl[5:0];
                if (shv[63:32] != 32'd0) begin
                    sh_ovf = 1'b1;
                    sh_res = 32'hFFFFFFFF;
                end else begin
                    sh_res = shv[31:0];
                end
            end
        end else if (sr <= 18'sd31) begin
            sh_res = sum_reg >> sr[4:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            phe_pkg::EX_IDLE: if (start) state_next = phe_pkg::EX_KFIX;
            phe_pkg::EX_KFIX: state_next = phe_pkg::EX_T1;
            phe_pkg::EX_T1:   state_next = phe_pkg::EX_T2;
            phe_pkg::EX_T2:   state_next = phe_pkg::EX_T3;
            phe_pkg::EX_T3: begin
                state_next = (n_reg == 4'(phe_pkg::EXP_TERMS)) ?
                             phe_pkg::EX_SH : phe_pkg::EX_T1;
            end
            phe_pkg::EX_SH:   state_next = phe_pkg::EX_IDLE;
            default:          state_next = phe_pkg::EX_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= phe_pkg::EX_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= state_reg == phe_pkg::EX_SH;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            phe_pkg::EX_IDLE: begin
                xoff_reg <= xoff;
                kq_reg   <= 66'(xoff) * 66'(phe_pkg::K_RECIP);
            end
            phe_pkg::EX_KFIX: begin
                k_reg    <= $signed(18'(kq)) - 18'sd47276;
                r30_reg  <= {rem16[15:0], 14'd0};
                term_reg <= 31'h40000000;
                sum_reg  <= 32'h40000000;
                n_reg    <= 4'd1;
            end
            phe_pkg::EX_T1: begin
                p_reg <= 61'(term_reg) * 61'(r30_reg);
            end
            phe_pkg::EX_T2: begin
                a_reg  <= p_reg[60:30];
                dq_reg <= 64'(p_reg[60:30]) * 64'(phe_pkg::term_recip(n_reg));
            end
            phe_pkg::EX_T3: begin
                term_reg <= tq[30:0];
                sum_reg  <= sum_reg + tq;
                n_reg    <= n_reg + 4'd1;
            end
            phe_pkg::EX_SH: begin
                result_reg <= sh_res;
                ovf_reg    <= sh_ovf;
            end
            default: begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign ovf    = ovf_reg;

endmodule

// File: sv/phe_back.sv
// back end: stores, evaluation sequencer, shared multiplier and result register
module phe_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  phe_pkg::cmd_t q_dout,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,  // log_hazard, cum_hazard_entry, cum_hazard_exit
    output logic          m_tuser   // batch_bad
);

    localparam int NI     = phe_pkg::NUM_INTERVALS;
    localparam int NTD    = phe_pkg::NUM_TD_COVARIATES;
    localparam int NFX    = phe_pkg::NUM_FIXED_COVARIATES;
    localparam int IW     = phe_pkg::IW;
    localparam int CW     = phe_pkg::CNT_W;
    localparam int TD_AWX = phe_pkg::TD_AW;

    phe_pkg::back_state_t state_reg, state_next;
    phe_pkg::phase_t      phase_reg;

    logic signed [31:0] td_mem [phe_pkg::TD_DEPTH];
    logic signed [31:0] td_rdata_reg;
    logic signed [31:0] widths_reg [NI];
    logic signed [31:0] fxcoef_reg [phe_pkg::FX_DEPTH];
    logic signed [31:0] fxcov_reg  [phe_pkg::FX_DEPTH];
    logic signed [31:0] tdcov_reg  [NTD];

    logic [IW-1:0]      t0_reg, t1_reg, kmax_reg, k_reg, cur_t_reg;
    logic [31:0]        x0_reg, x1_reg;
    logic               last_reg;
    logic [CW-1:0]      i_reg;
    logic signed [63:0] acc_reg, acc0_reg, acc1_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] fpred_reg, lp_reg, lp1_reg, lh_reg;
    logic [31:0]        e_reg, h0_reg, h1_reg;
    logic signed [63:0] batch_reg, batch_next;
    logic               bad_reg, bad_next;
    logic               m_valid_reg;
    logic [95:0]        m_data_reg;
    logic               m_user_reg;

    logic               exp_start, exp_done, exp_ovf;
    logic [31:0]        exp_result;
    logic signed [31:0] exp_x;

    logic signed [32:0] opa, opb;
    logic signed [63:0] pf, acc_sum, add, lh_sum;
    logic signed [64:0] bsum;
    logic [TD_AWX-1:0]  td_addr;
    logic               flag_set;
    logic               fx_last, td_last, k_last, out_load, is_load;
    logic [31:0]        h0c, h1c;
    logic [IW-1:0]      kmax_in;

    assign pf       = 64'(prod_reg >>> 16);
    assign acc_sum  = acc_reg + pf;
    assign fx_last  = i_reg == CW'(NFX - 1);
    assign td_last  = i_reg == CW'(NTD - 1);
    assign k_last   = k_reg == (kmax_reg - IW'(1));
    assign out_load = (state_reg == phe_pkg::ST_OUT) && (!m_valid_reg || m_tready);
    assign is_load  = (q_dout.op != phe_pkg::OP_EVAL);
    assign q_pop    = (state_reg == phe_pkg::ST_IDLE) && !q_empty;
    assign kmax_in  = (q_dout.t0 > q_dout.t1) ? q_dout.t0 : q_dout.t1;
    assign td_addr  = TD_AWX'(32'(i_reg[phe_pkg::TC_AW-1:0]) * 32'(NI) + 32'(cur_t_reg));
    assign h0c      = phe_pkg::clamp_u32(acc0_reg);
    assign h1c      = phe_pkg::clamp_u32(acc1_reg);
    assign add      = 64'(lp1_reg) + $signed(64'(h1c)) + 64'(fpred_reg);
    assign bsum     = 65'(batch_reg) + 65'(add);
    assign lh_sum   = 64'(lp1_reg) + 64'(fpred_reg);
    assign exp_x    = (phase_reg == phe_pkg::PH_FE) ? fpred_reg : lp_reg;
    assign exp_start = state_reg == phe_pkg::ST_EXP_GO;

    phe_exp u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (exp_start),
        .x       (exp_x),
        .done    (exp_done),
        .result  (exp_result),
        .ovf     (exp_ovf)
    );

    // multiplier operand select
    always_comb begin
        opa = '0;
        opb = '0;
        case (state_reg)
            phe_pkg::ST_FX_MUL: begin
                opa = 33'(fxcov_reg[i_reg[phe_pkg::FX_AW-1:0]]);
                opb = 33'(fxcoef_reg[i_reg[phe_pkg::FX_AW-1:0]]);
            end
            phe_pkg::ST_TD_MUL: begin
                opa = 33'(td_rdata_reg);
                opb = 33'(tdcov_reg[i_reg[phe_pkg::TC_AW-1:0]]);
            end
            phe_pkg::ST_TIME_MUL: begin
                opa = $signed({1'b0, e_reg});
                opb = $signed({1'b0, (phase_reg == phe_pkg::PH_LP0) ? x0_reg : x1_reg});
            end
            phe_pkg::ST_WID_MUL: begin
                opa = $signed({1'b0, e_reg});
                opb = 33'(widths_reg[k_reg]);
            end
            phe_pkg::ST_SC0_MUL: begin
                opa = $signed({1'b0, h0_reg});
                opb = $signed({1'b0, e_reg});
            end
            phe_pkg::ST_SC1_MUL: begin
                opa = $signed({1'b0, h1_reg});
                opb = $signed({1'b0, e_reg});
            end
            default: begin
            end
        endcase
    end

    // saturation events and batch accumulator
    always_comb begin
        flag_set   = 1'b0;
        batch_next = batch_reg;
        case (state_reg)
            phe_pkg::ST_FX_END:   flag_set = phe_pkg::out_of_s32(acc_reg);
            phe_pkg::ST_TD_ACC:   flag_set = td_last && phe_pkg::out_of_s32(acc_sum);
            phe_pkg::ST_EXP_WAIT: flag_set = exp_done && exp_ovf;
            phe_pkg::ST_FIN: begin
                if (bsum[64] != bsum[63]) begin
                    batch_next = bsum[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
                end else begin
                    batch_next = bsum[63:0];
                end
                flag_set = phe_pkg::out_of_u32(acc0_reg) || phe_pkg::out_of_u32(acc1_reg) ||
                           (bsum[64] != bsum[63]) || phe_pkg::out_of_s32(lh_sum);
            end
            phe_pkg::ST_SC0:      flag_set = phe_pkg::out_of_u32(pf);
            phe_pkg::ST_SC1:      flag_set = phe_pkg::out_of_u32(pf);
            default: begin
            end
        endcase
        bad_next = bad_reg | flag_set;
        if (out_load && last_reg) begin
            bad_next   = 1'b0;
            batch_next = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            phe_pkg::ST_IDLE: begin
                if (!q_empty && !is_load) begin
                    state_next = (NFX > 0) ? phe_pkg::ST_FX_MUL : phe_pkg::ST_FX_END;
                end
            end
            phe_pkg::ST_FX_MUL: state_next = phe_pkg::ST_FX_ACC;
            phe_pkg::ST_FX_ACC: state_next = fx_last ? phe_pkg::ST_FX_END : phe_pkg::ST_FX_MUL;
            phe_pkg::ST_FX_END: state_next = phe_pkg::ST_TD_RD;
            phe_pkg::ST_TD_RD:  state_next = phe_pkg::ST_TD_MUL;
            phe_pkg::ST_TD_MUL: state_next = phe_pkg::ST_TD_ACC;
            phe_pkg::ST_TD_ACC: state_next = td_last ? phe_pkg::ST_EXP_GO : phe_pkg::ST_TD_RD;
            phe_pkg::ST_EXP_GO: state_next = phe_pkg::ST_EXP_WAIT;
            phe_pkg::ST_EXP_WAIT: begin
                if (exp_done) begin
                    case (phase_reg)
                        phe_pkg::PH_LP0: state_next = phe_pkg::ST_TIME_MUL;
                        phe_pkg::PH_LP1: state_next = phe_pkg::ST_TIME_MUL;
                        phe_pkg::PH_K:   state_next = phe_pkg::ST_WID_MUL;
                        default:         state_next = phe_pkg::ST_FIN;
                    endcase
                end
            end
            phe_pkg::ST_TIME_MUL: state_next = phe_pkg::ST_TIME_ACC;
            phe_pkg::ST_TIME_ACC: begin
                if (phase_reg == phe_pkg::PH_LP1 && kmax_reg == IW'(0)) begin
                    state_next = phe_pkg::ST_EXP_GO;
                end else begin
                    state_next = phe_pkg::ST_TD_RD;
                end
            end
            phe_pkg::ST_WID_MUL: state_next = phe_pkg::ST_WID_ACC;
            phe_pkg::ST_WID_ACC: state_next = k_last ? phe_pkg::ST_EXP_GO : phe_pkg::ST_TD_RD;
            phe_pkg::ST_FIN:     state_next = phe_pkg::ST_SC0_MUL;
            phe_pkg::ST_SC0_MUL: state_next = phe_pkg::ST_SC0;
            phe_pkg::ST_SC0:     state_next = phe_pkg::ST_SC1_MUL;
            phe_pkg::ST_SC1_MUL: state_next = phe_pkg::ST_SC1;
            phe_pkg::ST_SC1:     state_next = phe_pkg::ST_OUT;
            phe_pkg::ST_OUT:     if (out_load) state_next = phe_pkg::ST_IDLE;
            default:             state_next = phe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= phe_pkg::ST_IDLE;
            bad_reg     <= 1'b0;
            batch_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            bad_reg   <= bad_next;
            batch_reg <= batch_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // coefficient table: written on load, read registered
    always_ff @(posedge aclk) begin
        if (q_pop && q_dout.op == phe_pkg::OP_TD_COEF) begin
            td_mem[TD_AWX'(q_dout.index)] <= q_dout.data;
        end
        td_rdata_reg <= td_mem[td_addr];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= opa * opb;
        case (state_reg)
            phe_pkg::ST_IDLE: begin
                if (q_pop) begin
                    case (q_dout.op)
                        phe_pkg::OP_WIDTH:   widths_reg[IW'(q_dout.index)] <= q_dout.data;
                        phe_pkg::OP_FX_COEF:
                            fxcoef_reg[phe_pkg::FX_AW'(q_dout.index)] <= q_dout.data;
                        phe_pkg::OP_TD_COV:
                            tdcov_reg[phe_pkg::TC_AW'(q_dout.index)] <= q_dout.data;
                        phe_pkg::OP_FX_COV:
                            fxcov_reg[phe_pkg::FX_AW'(q_dout.index)] <= q_dout.data;
                        default: begin
                        end
                    endcase
                end
                t0_reg   <= q_dout.t0;
                t1_reg   <= q_dout.t1;
                x0_reg   <= q_dout.x0;
                x1_reg   <= q_dout.x1;
                last_reg <= q_dout.last;
                kmax_reg <= kmax_in;
                acc_reg  <= '0;
                i_reg    <= '0;
            end
            phe_pkg::ST_FX_ACC: begin
                acc_reg <= acc_sum;
                i_reg   <= i_reg + CW'(1);
            end
            phe_pkg::ST_FX_END: begin
                fpred_reg <= phe_pkg::sat_s32(acc_reg);
                phase_reg <= phe_pkg::PH_LP0;
                cur_t_reg <= t0_reg;
                i_reg     <= '0;
                acc_reg   <= '0;
            end
            phe_pkg::ST_TD_ACC: begin
                acc_reg <= acc_sum;
                i_reg   <= i_reg + CW'(1);
                if (td_last) begin
                    lp_reg <= phe_pkg::sat_s32(acc_sum);
                    if (phase_reg == phe_pkg::PH_LP1) begin
                        lp1_reg <= phe_pkg::sat_s32(acc_sum);
                    end
                end
            end
            phe_pkg::ST_EXP_WAIT: begin
                e_reg <= exp_result;
            end
            phe_pkg::ST_TIME_ACC: begin
                i_reg   <= '0;
                acc_reg <= '0;
                if (phase_reg == phe_pkg::PH_LP0) begin
                    acc0_reg  <= pf;
                    phase_reg <= phe_pkg::PH_LP1;
                    cur_t_reg <= t1_reg;
                end else begin
                    acc1_reg  <= pf;
                    k_reg     <= '0;
                    cur_t_reg <= '0;
                    phase_reg <= (kmax_reg == IW'(0)) ? phe_pkg::PH_FE : phe_pkg::PH_K;
                end
            end
            phe_pkg::ST_WID_ACC: begin
                if (k_reg < t0_reg) begin
                    acc0_reg <= acc0_reg + pf;
                end
                if (k_reg < t1_reg) begin
                    acc1_reg <= acc1_reg + pf;
                end
                i_reg     <= '0;
                acc_reg   <= '0;
                k_reg     <= k_reg + IW'(1);
                cur_t_reg <= k_reg + IW'(1);
                if (k_last) begin
                    phase_reg <= phe_pkg::PH_FE;
                end
            end
            phe_pkg::ST_FIN: begin
                h0_reg <= h0c;
                h1_reg <= h1c;
                lh_reg <= phe_pkg::sat_s32(lh_sum);
            end
            phe_pkg::ST_SC0: h0_reg <= phe_pkg::clamp_u32(pf);
            phe_pkg::ST_SC1: h1_reg <= phe_pkg::clamp_u32(pf);
            phe_pkg::ST_OUT: begin
                if (out_load) begin
                    m_data_reg <= {h1_reg, h0_reg, lh_reg};
                    m_user_reg <= bad_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    a_batch_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_reg) |=> (!bad_reg && batch_reg == 64'sd0))
        else $error("batch state not cleared after last observation");

    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(bad_reg) && $past(aresetn)) |-> $past(out_load && last_reg))
        else $error("bad flag dropped inside a batch");

    a_exp_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_done |-> (state_reg == phe_pkg::ST_EXP_WAIT))
        else $error("exponential finished while sequencer not waiting");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == phe_pkg::ST_OUT))
        else $error("result shown without passing the output state");
`endif

endmodule

// File: sv/piecewise_hazard_evaluator_top.sv
// top level of the piecewise-constant hazard evaluator
// load beats are consumed in the idle state of the back end; the queue holds 2 commands
// evaluate runs the shared exponential unit once each for the entry and exit intervals,
// for each interval below max(entry, exit interval) and for the fixed predictor term
// the next beat is taken while a result waits
// aresetn (synchronous, active low) clears sequencer, queue, batch sum and bad flag; stores
// are not cleared
module piecewise_hazard_evaluator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // index, data_value, entry_interval, entry_time_in_interval,
                                   // exit_interval, exit_time_in_interval, zero pad
    input  logic [2:0]   s_tuser,  // opcode
    input  logic         s_tlast,  // last_observation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // log_hazard, cum_hazard_entry, cum_hazard_exit
    output logic         m_tuser   // batch_bad
);

    phe_pkg::cmd_t q_din, q_dout;
    logic          q_push, q_pop, q_empty, q_full;

    phe_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_din    (q_din)
    );

    phe_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty),
        .full    (q_full)
    );

    phe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_dout   (q_dout),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
